@@ src/assert_macros.svh @@
// Assertion macros shared by the hash table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define LPH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Implication checked on every clock edge outside reset.
`define LPH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ src/lph_pkg.sv @@
// Shared types, constants and helpers of the linear probing hash table.
package lph_pkg;

  // Table geometry
  localparam int SLOTS  = 32;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int SIZE_W = 6;
  localparam int N_W    = (SIZE_W > CNT_W) ? SIZE_W : CNT_W;

  // Payload widths
  localparam int OP_W  = 2;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;

  // Home slot divider: key bits per step and step count
  localparam int DIGIT_BITS = 4;
  localparam int DIV_STEPS  = KEY_W / DIGIT_BITS;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(19);

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [ST_W-1:0]   status_t;
  typedef logic [1:0]        flag_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [N_W-1:0]    size_t;

  // Operation codes
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_LOOKUP = 2'd2;

  // Result status codes
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_BADKEY   = 3'd2;
  localparam status_t ST_DUP      = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;
  localparam status_t ST_EMPTY    = 3'd5;

  // Slot flags
  localparam flag_t FLAG_EMPTY = 2'd0;
  localparam flag_t FLAG_USED  = 2'd1;
  localparam flag_t FLAG_TOMB  = 2'd2;

  // Classified item handed from front to back
  typedef struct packed {
    op_t                     op;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
    slot_t                   home;
  } item_t;

  // Size in use: zero acts as one, large values saturate to the slot count
  function automatic size_t eff_size(input logic [SIZE_W-1:0] s);
    size_t e;
    e = N_W'(s);
    if (e == '0) e = N_W'(1);
    if (e > N_W'(SLOTS)) e = N_W'(SLOTS);
    return e;
  endfunction

endpackage

@@ src/lph_if.sv @@
// Valid/ready channel interfaces for request and result beats.
interface lph_in_if;
  import lph_pkg::*;
  logic                    valid;
  logic                    ready;
  op_t                     operation;
  logic signed [KEY_W-1:0] key;
  logic signed [VAL_W-1:0] value_in;

  modport source (output valid, operation, key, value_in, input ready);
  modport sink   (input valid, operation, key, value_in, output ready);
endinterface

interface lph_out_if;
  import lph_pkg::*;
  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic signed [VAL_W-1:0] value_out;
  slot_t                   slot;

  modport source (output valid, status, value_out, slot, input ready);
  modport sink   (input valid, status, value_out, slot, output ready);
endinterface

@@ src/lph_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/lph_front.sv @@
// Front end: takes request beats and works out the home slot, key mod size.
`include "assert_macros.svh"

module lph_front (
  input  logic           clk,
  input  logic           rst_n,
  input  lph_pkg::size_t n,
  lph_in_if.sink         in_ch,
  output logic           push_valid,
  input  logic           push_ready,
  output lph_pkg::item_t push_item
);
  import lph_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [KEY_W-1:0] shreg_r, shreg_nxt;
  size_t            rem_r, rem_nxt;
  item_t            item_r, item_nxt;
  size_t            rem_tmp;

  // One restoring step: shift in a key bit, subtract the modulus if it fits
  function automatic size_t mod_step(input size_t r, input logic b, input size_t m);
    logic [N_W:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[N_W-1:0];
  endfunction

  assign in_ch.ready = (state_r == F_IDLE);
  assign push_valid  = (state_r == F_PUSH);
  assign push_item   = item_r;

  // Four key bits per cycle, most significant first
  always_comb begin
    rem_tmp = rem_r;
    for (int j = 0; j < DIGIT_BITS; j++) begin
      rem_tmp = mod_step(rem_tmp, shreg_r[KEY_W-1-j], n);
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    shreg_nxt = shreg_r;
    rem_nxt   = rem_r;
    item_nxt  = item_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_ch.valid) begin
          item_nxt.op    = in_ch.operation;
          item_nxt.key   = in_ch.key;
          item_nxt.value = in_ch.value_in;
          item_nxt.home  = '0;
          shreg_nxt      = in_ch.key;
          rem_nxt        = '0;
          step_nxt       = '0;
          state_nxt      = F_DIV;
        end
      end
      F_DIV: begin
        rem_nxt   = rem_tmp;
        shreg_nxt = shreg_r << DIGIT_BITS;
        step_nxt  = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          item_nxt.home = SLOT_W'(rem_tmp);
          state_nxt     = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    shreg_r <= shreg_nxt;
    rem_r   <= rem_nxt;
    item_r  <= item_nxt;
  end

  // Residue stays below the modulus once the division has begun
  `LPH_ASSERT_IMP(a_rem_below_n, state_r == F_DIV, rem_r < n, "front residue out of range")

endmodule

@@ src/lph_queue.sv @@
// Two-entry queue between front and back ends.
`include "assert_macros.svh"

module lph_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  lph_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output lph_pkg::item_t pop_item
);
  import lph_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

  `LPH_ASSERT(a_count_range, count_r <= 2'd2, "queue count overflow")
  `LPH_ASSERT_IMP(a_ptrs_when_full, count_r == 2'd2, wr_ptr_r == rd_ptr_r,
                  "queue pointers disagree with count")

endmodule

@@ src/lph_back.sv @@
// Back end: probes the slot table, applies insert/remove/lookup, holds the result.
`include "assert_macros.svh"

module lph_back (
  input  logic           clk,
  input  logic           rst_n,
  input  lph_pkg::size_t n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  lph_pkg::item_t head,
  lph_out_if.source      out_ch
);
  import lph_pkg::*;

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_READ  = 2'd1;
  localparam logic [1:0] B_CHECK = 2'd2;
  localparam logic [1:0] B_DONE  = 2'd3;

  localparam int RAM_W = KEY_W - 1 + VAL_W;

  logic [1:0]              state_r, state_nxt;
  item_t                   cur_r, cur_nxt;
  slot_t                   pos_r, pos_nxt;
  size_t                   cnt_r, cnt_nxt;
  logic                    free_v_r, free_v_nxt;
  slot_t                   free_r, free_nxt;
  logic [CNT_W-1:0]        live_r, live_nxt;
  status_t                 res_status_r, res_status_nxt;
  logic signed [VAL_W-1:0] res_value_r, res_value_nxt;
  slot_t                   res_slot_r, res_slot_nxt;

  flag_t                   flag_r [SLOTS];
  logic                    flag_we;
  slot_t                   flag_widx;
  flag_t                   flag_wval;

  logic                    ram_we;
  slot_t                   ram_waddr;
  logic [RAM_W-1:0]        ram_rdata;

  logic                    out_valid_r;
  status_t                 out_status_r;
  logic signed [VAL_W-1:0] out_value_r;
  slot_t                   out_slot_r;

  flag_t                   cur_flag;
  logic                    hit, last, is_ins, is_rem, head_ins, head_rem, head_neg;
  slot_t                   place_idx;
  logic                    out_load;

  // Key and data store, one slot per entry
  lph_ram #(.WIDTH(RAM_W), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({cur_r.key[KEY_W-2:0], cur_r.value}),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  // Probe classification
  assign cur_flag  = flag_r[pos_r];
  assign hit       = (cur_flag == FLAG_USED) && (ram_rdata[RAM_W-1:VAL_W] == cur_r.key[KEY_W-2:0]);
  assign last      = (cnt_r == n - N_W'(1));
  assign is_ins    = (cur_r.op == OP_INSERT);
  assign is_rem    = (cur_r.op == OP_REMOVE);
  assign head_ins  = (head.op == OP_INSERT);
  assign head_rem  = (head.op == OP_REMOVE);
  assign head_neg  = head.key[KEY_W-1];
  assign place_idx = free_v_r ? free_r : pos_r;
  assign out_load  = (state_r == B_DONE) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.value_out = out_value_r;
  assign out_ch.slot      = out_slot_r;

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    free_v_nxt     = free_v_r;
    free_nxt       = free_r;
    live_nxt       = live_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_slot_nxt   = res_slot_r;
    flag_we        = 1'b0;
    flag_widx      = pos_r;
    flag_wval      = FLAG_USED;
    ram_we         = 1'b0;
    ram_waddr      = place_idx;
    pop_ready      = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          cur_nxt        = head;
          pos_nxt        = head.home;
          cnt_nxt        = '0;
          free_v_nxt     = 1'b0;
          res_status_nxt = ST_OK;
          res_value_nxt  = '0;
          res_slot_nxt   = '0;
          state_nxt      = B_READ;
          // Checks that need no probe
          if (head_ins && (N_W'(live_r) >= n)) begin
            res_status_nxt = ST_FULL;
            state_nxt      = B_DONE;
          end else if (head_ins && head_neg) begin
            res_status_nxt = ST_BADKEY;
            state_nxt      = B_DONE;
          end else if (head_rem && (live_r == '0)) begin
            res_status_nxt = ST_EMPTY;
            state_nxt      = B_DONE;
          end else if (!head_ins && head_neg) begin
            res_status_nxt = ST_NOTFOUND;
            state_nxt      = B_DONE;
          end
        end
      end
      B_READ: begin
        state_nxt = B_CHECK;
      end
      B_CHECK: begin
        if (hit) begin
          // Key present
          state_nxt = B_DONE;
          if (is_ins) begin
            res_status_nxt = ST_DUP;
          end else begin
            res_value_nxt = ram_rdata[VAL_W-1:0];
            res_slot_nxt  = pos_r;
            if (is_rem) begin
              flag_we   = 1'b1;
              flag_wval = FLAG_TOMB;
              live_nxt  = live_r - 1'b1;
            end
          end
        end else if ((cur_flag == FLAG_EMPTY) || last) begin
          // Search ends without a match
          state_nxt = B_DONE;
          if (is_ins) begin
            if ((cur_flag != FLAG_USED) || free_v_r) begin
              flag_we      = 1'b1;
              flag_widx    = place_idx;
              flag_wval    = FLAG_USED;
              ram_we       = 1'b1;
              live_nxt     = live_r + 1'b1;
              res_slot_nxt = place_idx;
            end else begin
              res_status_nxt = ST_FULL;
            end
          end else begin
            res_status_nxt = ST_NOTFOUND;
          end
        end else begin
          // Remember first reusable slot, step to the next one
          if ((cur_flag != FLAG_USED) && !free_v_r) begin
            free_v_nxt = 1'b1;
            free_nxt   = pos_r;
          end
          pos_nxt   = ((N_W'(pos_r) + N_W'(1)) == n) ? '0 : pos_r + 1'b1;
          cnt_nxt   = cnt_r + N_W'(1);
          state_nxt = B_READ;
        end
      end
      B_DONE: begin
        if (out_load) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      live_r  <= live_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Slot flags, cleared to empty at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) flag_r[i] <= FLAG_EMPTY;
    end else if (flag_we) begin
      flag_r[flag_widx] <= flag_wval;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    pos_r        <= pos_nxt;
    cnt_r        <= cnt_nxt;
    free_v_r     <= free_v_nxt;
    free_r       <= free_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_slot_r   <= res_slot_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_slot_r   <= res_slot_r;
    end
  end

  `LPH_ASSERT(a_live_max, live_r <= CNT_W'(SLOTS), "live count exceeds slot count")
  `LPH_ASSERT_IMP(a_probe_lap, state_r == B_CHECK, cnt_r < n, "probe ran past one lap")

endmodule

@@ src/linear_probe_hash_table.sv @@
// Linear probing hash table: top level with size register and front/queue/back.
//
// Channels: in_ch carries request beats (operation, key, value_in) and out_ch
// carries one result beat (status, value_out, slot) per request, in order.
// Both use valid/ready; a beat moves when both are high on a rising edge.
// cfg_we/cfg_wdata write table_size; write it only while the block is idle.
// Flow: the front takes the beat, works out key mod size (4 key bits a cycle)
// and hands the item to the queue; the back pops the queue, reads and checks
// each probed slot in turn (B_READ, then B_CHECK), loads the result register
// in B_DONE and moves the result beat.
// Throughput: the front takes no new request until it has handed off the last
// one and the back works on one request at a time; requests with more than 4
// probes make the back the slower side and set the pace, and the two-entry
// queue absorbs the difference.
// Reset (rst_n low, synchronous) empties every slot, clears the live count and
// sets table_size to 19; no clearing pass is needed.
// A stalled receiver holds the result register; the back waits with the next
// result and the queue and front keep taking requests until they fill.
module linear_probe_hash_table (
  input  logic                       clk,
  input  logic                       rst_n,
  lph_in_if.sink                     in_ch,
  lph_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [lph_pkg::SIZE_W-1:0] cfg_wdata
);
  import lph_pkg::*;

  logic [SIZE_W-1:0] table_size_r;
  size_t             n;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  item_t             push_item, pop_item;

  // Size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      table_size_r <= cfg_wdata;
    end
  end

  assign n = eff_size(table_size_r);

  lph_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .n          (n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  lph_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  lph_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .n         (n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .head      (pop_item),
    .out_ch    (out_ch)
  );

endmodule
